// ===== hdl/qvr_pkg.sv =====
// Shared constants for the quaternion vector rotation pipeline.
`default_nettype none
package qvr_pkg;
	// Magnitude bound (in bits) that the normalize path scales each component under.
	localparam int NORM_BITS = 30;
	// Shift-subtract steps done per pipeline stage in the square root and divider.
	localparam int ITER_PER_STAGE = 2;
endpackage
`default_nettype wire

// ===== hdl/quaternion_vector_rotation.sv =====
// Top level: rotation r = q*(0,v)*conj(q) with optional normalize, fully pipelined.
`default_nettype none
// Accepts one transaction per clock (busy is always low) and returns each result on done after
// the product, coefficient, multiply, sum, rounding and scaling stages,
// ceil((NORM_BITS+1)/2) square-root stages, 1 + ceil((VEC_BITS/2 + 1)/2) divider stages
// and one output register. Both modes pass through every stage, so results leave in order
// of acceptance. A non-unit quaternion scales the vector by its squared norm. Mode 1 returns
// a unit vector, or zeros with zero_length set when the rotated vector is zero. Results
// cannot be held off.
module quaternion_vector_rotation import qvr_pkg::*; #(
	parameter int QUAT_BITS = 16,
	parameter int VEC_BITS  = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic signed [QUAT_BITS-1:0] quat_w,
	input  wire logic signed [QUAT_BITS-1:0] quat_x,
	input  wire logic signed [QUAT_BITS-1:0] quat_y,
	input  wire logic signed [QUAT_BITS-1:0] quat_z,
	input  wire logic signed [VEC_BITS-1:0]  vec_x,
	input  wire logic signed [VEC_BITS-1:0]  vec_y,
	input  wire logic signed [VEC_BITS-1:0]  vec_z,
	input  wire logic                        mode,
	output logic                             done,
	output logic signed [VEC_BITS-1:0]       out_x,
	output logic signed [VEC_BITS-1:0]       out_y,
	output logic signed [VEC_BITS-1:0]       out_z,
	output logic                             zero_length,
	output logic                             saturated
);
	localparam int QB = QUAT_BITS;
	localparam int VB = VEC_BITS;
	localparam int VF = VEC_BITS / 2;
	localparam int F2 = 2 * (QUAT_BITS - 1);
	localparam int PW = 2 * QB;
	localparam int CW = PW + 2;
	localparam int TW = CW + VB;
	localparam int RW = TW + 2;
	localparam int LW = $clog2(RW + 1);
	localparam int NB = NORM_BITS;
	localparam int SW = 2 * NB + 2;
	localparam int QW = VF + 1;

	typedef struct packed {
		logic                   mode;
		logic                   zero;
		logic [2:0]             neg;
		logic [2:0][VB-1:0]     out0;
		logic                   sat0;
	} div_side_t;

	typedef struct packed {
		div_side_t              rest;
		logic [2:0][NB-1:0]     a;
	} sqrt_side_t;

	// Never stalls: every start is taken.
	assign busy = 1'b0;

	// Stage 1: quadratic terms of the quaternion.
	logic                 valid_s1, mode_s1;
	logic signed [PW-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;
	logic signed [VB-1:0] v_s1 [3];

	// Stage 2: rotation matrix entries.
	logic                 valid_s2, mode_s2;
	logic signed [CW-1:0] c_s2 [3][3];
	logic signed [VB-1:0] v_s2 [3];

	// Stage 3: matrix-vector products.
	logic                 valid_s3, mode_s3;
	logic signed [TW-1:0] t_s3 [3][3];

	// Stage 4: row sums.
	logic                 valid_s4, mode_s4;
	logic signed [RW-1:0] r_s4 [3];

	// Stage 5: sign and magnitude.
	logic                 valid_s5, mode_s5;
	logic [2:0]           neg_s5;
	logic [RW-1:0]        m_s5 [3];

	// Stage 6: mode 0 result, bit length for normalize.
	logic                 valid_s6, mode_s6, sat0_s6;
	logic [2:0]           neg_s6;
	logic [RW-1:0]        m_s6 [3];
	logic [LW-1:0]        len_s6;
	logic [2:0][VB-1:0]   out0_s6;

	// Stage 7: scaled magnitudes.
	logic                 valid_s7, mode_s7, sat0_s7, zero_s7;
	logic [2:0]           neg_s7;
	logic [2:0][VB-1:0]   out0_s7;
	logic [2:0][NB-1:0]   a_s7;

	// Stage 8: squares.
	logic                 valid_s8;
	div_side_t            rest_s8;
	logic [2:0][NB-1:0]   a_s8;
	logic [SW-1:0]        sq_s8 [3];

	// Stage 9: sum of squares.
	logic                 valid_s9;
	sqrt_side_t           side_s9;
	logic [SW-1:0]        sum_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
		end
	end

	always_ff @(posedge clk) begin
		mode_s1 <= mode;
		ww_s1   <= PW'(quat_w) * PW'(quat_w);
		xx_s1   <= PW'(quat_x) * PW'(quat_x);
		yy_s1   <= PW'(quat_y) * PW'(quat_y);
		zz_s1   <= PW'(quat_z) * PW'(quat_z);
		xy_s1   <= PW'(quat_x) * PW'(quat_y);
		wz_s1   <= PW'(quat_w) * PW'(quat_z);
		xz_s1   <= PW'(quat_x) * PW'(quat_z);
		wy_s1   <= PW'(quat_w) * PW'(quat_y);
		yz_s1   <= PW'(quat_y) * PW'(quat_z);
		wx_s1   <= PW'(quat_w) * PW'(quat_x);
		v_s1[0] <= vec_x;
		v_s1[1] <= vec_y;
		v_s1[2] <= vec_z;
	end

	always_ff @(posedge clk) begin
		mode_s2    <= mode_s1;
		v_s2       <= v_s1;
		c_s2[0][0] <= CW'(ww_s1) + CW'(xx_s1) - CW'(yy_s1) - CW'(zz_s1);
		c_s2[0][1] <= (CW'(xy_s1) - CW'(wz_s1)) <<< 1;
		c_s2[0][2] <= (CW'(xz_s1) + CW'(wy_s1)) <<< 1;
		c_s2[1][0] <= (CW'(xy_s1) + CW'(wz_s1)) <<< 1;
		c_s2[1][1] <= CW'(ww_s1) - CW'(xx_s1) + CW'(yy_s1) - CW'(zz_s1);
		c_s2[1][2] <= (CW'(yz_s1) - CW'(wx_s1)) <<< 1;
		c_s2[2][0] <= (CW'(xz_s1) - CW'(wy_s1)) <<< 1;
		c_s2[2][1] <= (CW'(yz_s1) + CW'(wx_s1)) <<< 1;
		c_s2[2][2] <= CW'(ww_s1) - CW'(xx_s1) - CW'(yy_s1) + CW'(zz_s1);
	end

	always_ff @(posedge clk) begin
		mode_s3 <= mode_s2;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				t_s3[i][j] <= TW'(c_s2[i][j]) * TW'(v_s2[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_s4 <= mode_s3;
		for (int i = 0; i < 3; i++) begin
			r_s4[i] <= RW'(t_s3[i][0]) + RW'(t_s3[i][1]) + RW'(t_s3[i][2]);
		end
	end

	always_ff @(posedge clk) begin
		mode_s5 <= mode_s4;
		for (int i = 0; i < 3; i++) begin
			neg_s5[i] <= r_s4[i][RW-1];
			m_s5[i]   <= r_s4[i][RW-1] ? RW'(-r_s4[i]) : RW'(r_s4[i]);
		end
	end

	// Mode 0: round half away from zero, then clip to the signed output range.
	logic [2:0][VB-1:0] out0_nxt;
	logic               sat0_nxt;
	logic [LW-1:0]      len_nxt;

	always_comb begin : round_clip
		logic [RW:0]        rnd;
		logic [RW:0]        lim;
		logic [RW:0]        mag;
		logic [RW-1:0]      any;
		sat0_nxt = 1'b0;
		for (int i = 0; i < 3; i++) begin
			rnd = ((RW+1)'(m_s5[i]) + ((RW+1)'(1) << (F2 - 1))) >> F2;
			lim = ((RW+1)'(1) << (VB - 1)) - (neg_s5[i] ? (RW+1)'(0) : (RW+1)'(1));
			mag = rnd;
			if (rnd > lim) begin
				mag      = lim;
				sat0_nxt = 1'b1;
			end
			out0_nxt[i] = neg_s5[i] ? VB'(-mag) : VB'(mag);
		end
		any     = m_s5[0] | m_s5[1] | m_s5[2];
		len_nxt = '0;
		for (int b = 0; b < RW; b++) begin
			if (any[b]) begin
				len_nxt = LW'(b + 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_s6 <= mode_s5;
		neg_s6  <= neg_s5;
		m_s6    <= m_s5;
		len_s6  <= len_nxt;
		out0_s6 <= out0_nxt;
		sat0_s6 <= sat0_nxt;
	end

	// Normalize: shift all magnitudes by one amount so the largest fits NORM_BITS.
	logic [LW-1:0] sh_s6;
	assign sh_s6 = (len_s6 > LW'(NB)) ? (len_s6 - LW'(NB)) : '0;

	always_ff @(posedge clk) begin
		mode_s7 <= mode_s6;
		neg_s7  <= neg_s6;
		out0_s7 <= out0_s6;
		sat0_s7 <= sat0_s6;
		zero_s7 <= (len_s6 == '0);
		for (int i = 0; i < 3; i++) begin
			a_s7[i] <= NB'(m_s6[i] >> sh_s6);
		end
	end

	always_ff @(posedge clk) begin
		rest_s8.mode <= mode_s7;
		rest_s8.zero <= zero_s7;
		rest_s8.neg  <= neg_s7;
		rest_s8.out0 <= out0_s7;
		rest_s8.sat0 <= sat0_s7;
		a_s8         <= a_s7;
		for (int i = 0; i < 3; i++) begin
			sq_s8[i] <= SW'(a_s7[i]) * SW'(a_s7[i]);
		end
	end

	always_ff @(posedge clk) begin
		side_s9.rest <= rest_s8;
		side_s9.a    <= a_s8;
		sum_s9       <= sq_s8[0] + sq_s8[1] + sq_s8[2];
	end

	logic          sq_valid;
	logic [NB:0]   sq_root;
	sqrt_side_t    sq_side;

	qvr_isqrt #(
		.RootBits (NB + 1),
		.SideBits ($bits(sqrt_side_t))
	) u_isqrt (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (valid_s9),
		.in_radicand (sum_s9),
		.in_side     (side_s9),
		.out_valid   (sq_valid),
		.out_root    (sq_root),
		.out_side    (sq_side)
	);

	logic [NB-1:0] dv_dividend [3];
	logic          dv_valid;
	logic [QW-1:0] dv_quot [3];
	div_side_t     dv_side;

	assign dv_dividend[0] = sq_side.a[0];
	assign dv_dividend[1] = sq_side.a[1];
	assign dv_dividend[2] = sq_side.a[2];

	qvr_div #(
		.OpBits   (NB),
		.FracBits (VF),
		.SideBits ($bits(div_side_t))
	) u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (sq_valid),
		.in_divisor  (sq_root),
		.in_dividend (dv_dividend),
		.in_side     (sq_side.rest),
		.out_valid   (dv_valid),
		.out_quot    (dv_quot),
		.out_side    (dv_side)
	);

	// Output stage: pick the mode result.
	logic [2:0][VB-1:0] res_nxt;
	logic               sat_nxt;
	logic               zl_nxt;

	always_comb begin : select_out
		logic [VB:0] lim;
		logic [VB:0] mag;
		logic        sat1;
		sat1 = 1'b0;
		for (int i = 0; i < 3; i++) begin
			lim = ((VB+1)'(1) << (VB - 1)) - (dv_side.neg[i] ? (VB+1)'(0) : (VB+1)'(1));
			mag = (VB+1)'(dv_quot[i]);
			if (mag > lim) begin
				mag  = lim;
				sat1 = 1'b1;
			end
			res_nxt[i] = dv_side.neg[i] ? VB'(-mag) : VB'(mag);
		end
		if (!dv_side.mode) begin
			res_nxt = dv_side.out0;
			sat_nxt = dv_side.sat0;
			zl_nxt  = 1'b0;
		end else if (dv_side.zero) begin
			res_nxt = '0;
			sat_nxt = 1'b0;
			zl_nxt  = 1'b1;
		end else begin
			sat_nxt = sat1;
			zl_nxt  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_x       <= res_nxt[0];
		out_y       <= res_nxt[1];
		out_z       <= res_nxt[2];
		zero_length <= zl_nxt;
		saturated   <= sat_nxt;
	end
endmodule
`default_nettype wire

// ===== hdl/qvr_isqrt.sv =====
// Pipelined floor square root, a fixed number of shift-subtract steps per stage.
`default_nettype none
module qvr_isqrt import qvr_pkg::*; #(
	parameter int RootBits = 31,
	parameter int SideBits = 1
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	input  wire logic [2*RootBits-1:0]   in_radicand,
	input  wire logic [SideBits-1:0]     in_side,
	output logic                         out_valid,
	output logic [RootBits-1:0]          out_root,
	output logic [SideBits-1:0]          out_side
);
	localparam int SW = 2 * RootBits;
	localparam int STAGES = (RootBits + ITER_PER_STAGE - 1) / ITER_PER_STAGE;

	logic [SW-1:0]       rem_s   [0:STAGES];
	logic [SW-1:0]       res_s   [0:STAGES];
	logic                valid_s [0:STAGES];
	logic [SideBits-1:0] side_s  [0:STAGES];

	assign rem_s[0]   = in_radicand;
	assign res_s[0]   = '0;
	assign valid_s[0] = in_valid;
	assign side_s[0]  = in_side;

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [SW-1:0] rem_nxt;
		logic [SW-1:0] res_nxt;

		always_comb begin : step
			logic [SW-1:0] bitv;
			logic [SW:0]   trial;
			int            idx;
			int            k;
			rem_nxt = rem_s[g];
			res_nxt = res_s[g];
			for (int j = 0; j < ITER_PER_STAGE; j++) begin
				idx = g * ITER_PER_STAGE + j;
				if (idx < RootBits) begin
					k     = RootBits - 1 - idx;
					bitv  = SW'(1) << (2 * k);
					trial = (SW+1)'(res_nxt) + (SW+1)'(bitv);
					if ((SW+1)'(rem_nxt) >= trial) begin
						rem_nxt = rem_nxt - SW'(trial);
						res_nxt = (res_nxt >> 1) + bitv;
					end else begin
						res_nxt = res_nxt >> 1;
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= rem_nxt;
			res_s[g+1]  <= res_nxt;
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_valid = valid_s[STAGES];
	assign out_root  = res_s[STAGES][RootBits-1:0];
	assign out_side  = side_s[STAGES];
endmodule
`default_nettype wire

// ===== hdl/qvr_div.sv =====
// Pipelined three-lane divider for the normalize path: round(a * 2^frac / len).
`default_nettype none
module qvr_div import qvr_pkg::*; #(
	parameter int OpBits   = 30,
	parameter int FracBits = 16,
	parameter int SideBits = 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [OpBits:0]       in_divisor,
	input  wire logic [OpBits-1:0]     in_dividend [3],
	input  wire logic [SideBits-1:0]   in_side,
	output logic                       out_valid,
	output logic [FracBits:0]          out_quot [3],
	output logic [SideBits-1:0]        out_side
);
	localparam int DW = OpBits + FracBits + 2;
	localparam int QW = FracBits + 1;
	localparam int STAGES = (QW + ITER_PER_STAGE - 1) / ITER_PER_STAGE;

	logic [DW-1:0]       rem_s   [0:STAGES][3];
	logic [QW-1:0]       quot_s  [0:STAGES][3];
	logic [OpBits:0]     div_s   [0:STAGES];
	logic                valid_s [0:STAGES];
	logic [SideBits-1:0] side_s  [0:STAGES];

	// Prep stage: form the rounded numerator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			rem_s[0][i]  <= (DW'(in_dividend[i]) << FracBits) + DW'(in_divisor >> 1);
			quot_s[0][i] <= '0;
		end
		div_s[0]  <= in_divisor;
		side_s[0] <= in_side;
	end

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [DW-1:0] rem_nxt  [3];
		logic [QW-1:0] quot_nxt [3];

		always_comb begin : step
			logic [DW-1:0] d;
			int            idx;
			int            k;
			for (int i = 0; i < 3; i++) begin
				rem_nxt[i]  = rem_s[g][i];
				quot_nxt[i] = quot_s[g][i];
			end
			for (int j = 0; j < ITER_PER_STAGE; j++) begin
				idx = g * ITER_PER_STAGE + j;
				if (idx < QW) begin
					k = QW - 1 - idx;
					d = DW'(div_s[g]) << k;
					for (int i = 0; i < 3; i++) begin
						if (rem_nxt[i] >= d) begin
							rem_nxt[i]     = rem_nxt[i] - d;
							quot_nxt[i][k] = 1'b1;
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[g+1] <= 1'b0;
			end else begin
				valid_s[g+1] <= valid_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= rem_nxt;
			quot_s[g+1] <= quot_nxt;
			div_s[g+1]  <= div_s[g];
			side_s[g+1] <= side_s[g];
		end
	end

	assign out_valid = valid_s[STAGES];
	assign out_quot  = quot_s[STAGES];
	assign out_side  = side_s[STAGES];
endmodule
`default_nettype wire
